// ----- rtl/macd_pkg.sv -----
// ----------------------------------------------------------------------------
// macd_pkg: shared types, constants and helpers
// Widths, controller state and phase codes, command/status bundles and
// saturation helpers used by the MACD indicator block.
// ----------------------------------------------------------------------------
`default_nettype none

package macd_pkg;

  localparam int PriceW  = 32;   // unsigned Q16.16 price
  localparam int ValW    = 40;   // signed Q24.16 averages and results
  localparam int PerW    = 11;   // period registers
  localparam int CntW    = 12;   // bar counter
  localparam int SeedW   = 48;   // price seed sums
  localparam int SigSumW = 52;   // signal seed sum
  localparam int NumW    = 54;   // divider numerator
  localparam int WideW   = 56;   // signed working width
  localparam int MaxPeriod = 1024;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  // register indexes
  localparam logic [1:0] RegFast   = 2'd0;
  localparam logic [1:0] RegSlow   = 2'd1;
  localparam logic [1:0] RegSignal = 2'd2;

  localparam logic [PerW-1:0] FastReset   = PerW'(12);
  localparam logic [PerW-1:0] SlowReset   = PerW'(26);
  localparam logic [PerW-1:0] SignalReset = PerW'(9);

  typedef enum logic [1:0] {
    PH_FAST,
    PH_SLOW,
    PH_SIG
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_START,
    S_DIV_RUN,
    S_DIV_WRITE,
    S_DIF,
    S_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic   load;
    logic   prep;
    logic   dif;
    logic   div_start;
    logic   div_write;
    logic   out_load;
    phase_e phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err;
    logic need_div;
    logic div_done;
  } dp_stat_t;

  // zero reads as one, large values clip to the maximum period
  function automatic logic [PerW-1:0] eff_period(input logic [PerW-1:0] r);
    logic [PerW-1:0] p;
    if (r == '0) p = PerW'(1);
    else if (r > PerW'(MaxPeriod)) p = PerW'(MaxPeriod);
    else p = r;
    return p;
  endfunction

  // saturate a wide signed value to the 40-bit result range
  function automatic logic [ValW-1:0] sat_val(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    logic [ValW-1:0]         r;
    hi = {{(WideW-ValW+1){1'b0}}, {(ValW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) r = {1'b0, {(ValW-1){1'b1}}};
    else if (v < lo) r = {1'b1, {(ValW-1){1'b0}}};
    else r = v[ValW-1:0];
    return r;
  endfunction

  // saturate a wide signed value to the 52-bit signal seed range
  function automatic logic [SigSumW-1:0] sat_sig(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    logic [SigSumW-1:0]      r;
    hi = {{(WideW-SigSumW+1){1'b0}}, {(SigSumW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) r = {1'b0, {(SigSumW-1){1'b1}}};
    else if (v < lo) r = {1'b1, {(SigSumW-1){1'b0}}};
    else r = v[SigSumW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/macd_indicator_stream.sv -----
// ----------------------------------------------------------------------------
// macd_indicator_stream: MACD indicator over a stream of closing prices
// Fast/slow exponential averages, dif, signal average and histogram per bar.
// ----------------------------------------------------------------------------
// One closing price (unsigned Q16.16) enters per beat and one result beat
// leaves per bar. Bars are processed one at a time: each bar runs up to three
// divisions (fast, slow, signal average) on the single shared serial divider,
// which produces one quotient bit per cycle; none run when fast is not below
// slow. A finished result waits in an output register while the next bar is
// accepted. Periods are written over the APB port at 0x0 (fast), 0x4 (slow),
// 0x8 (signal); 0 acts as 1 and values above 1024 act as 1024. series_start
// clears the running state.
`default_nettype none

module macd_indicator_stream (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // APB configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [macd_pkg::AddrW-1:0]   paddr,
  input  wire logic [macd_pkg::DataW-1:0]   pwdata,
  output logic [macd_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  // input beats
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [31:0]                  s_axis_tdata_i,  // close_price[31:0]
  input  wire logic                         s_axis_tuser_i,  // series_start
  // result beats
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [119:0]                      m_axis_tdata_o,  // dif[39:0], dea, hist
  output logic [2:0]                        m_axis_tuser_o   // dif_valid, dea_valid,
                                                             // period_error
);

  logic [macd_pkg::PerW-1:0] fast_q, slow_q, signal_q;
  logic                      wr_en;

  // period registers
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q   <= macd_pkg::FastReset;
      slow_q   <= macd_pkg::SlowReset;
      signal_q <= macd_pkg::SignalReset;
    end else if (wr_en) begin
      case (paddr[3:2])
        macd_pkg::RegFast:   fast_q   <= pwdata[macd_pkg::PerW-1:0];
        macd_pkg::RegSlow:   slow_q   <= pwdata[macd_pkg::PerW-1:0];
        macd_pkg::RegSignal: signal_q <= pwdata[macd_pkg::PerW-1:0];
        default:             fast_q   <= fast_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      macd_pkg::RegFast:   prdata = {{(macd_pkg::DataW-macd_pkg::PerW){1'b0}}, fast_q};
      macd_pkg::RegSlow:   prdata = {{(macd_pkg::DataW-macd_pkg::PerW){1'b0}}, slow_q};
      macd_pkg::RegSignal: prdata = {{(macd_pkg::DataW-macd_pkg::PerW){1'b0}}, signal_q};
      default:             prdata = '0;
    endcase
  end

  macd_pkg::ctrl_cmd_t cmd;
  macd_pkg::dp_stat_t  stat;
  logic [macd_pkg::ValW-1:0] dif_v, dea_v, hist_v;
  logic                      dif_ok, dea_ok, p_err;

  macd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  macd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .fast_reg_i     (fast_q),
    .slow_reg_i     (slow_q),
    .signal_reg_i   (signal_q),
    .close_price_i  (s_axis_tdata_i),
    .series_start_i (s_axis_tuser_i),
    .stat_o         (stat),
    .dif_value_o    (dif_v),
    .dea_value_o    (dea_v),
    .hist_value_o   (hist_v),
    .dif_valid_o    (dif_ok),
    .dea_valid_o    (dea_ok),
    .period_error_o (p_err)
  );

  assign m_axis_tdata_o = {hist_v, dea_v, dif_v};
  assign m_axis_tuser_o = {p_err, dea_ok, dif_ok};

endmodule

`default_nettype wire

// ----- rtl/macd_div.sv -----
// ----------------------------------------------------------------------------
// macd_div: serial unsigned divider
// Restoring divider, one quotient bit per cycle. The numerator already holds
// the rounding offset, so the quotient is the rounded result.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [macd_pkg::NumW-1:0] num_i,
  input  wire logic [macd_pkg::PerW-1:0] den_i,
  output logic                           done_o,
  output logic [macd_pkg::NumW-1:0]      quot_o
);

  localparam int CW = $clog2(macd_pkg::NumW);

  logic [macd_pkg::NumW-1:0] work_q, work_d;
  logic [macd_pkg::PerW-1:0] rem_q, rem_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [macd_pkg::PerW:0]   trial;
  logic                      qbit;

  // one shift-compare-subtract step
  always_comb begin
    trial  = {rem_q, work_q[macd_pkg::NumW-1]};
    qbit   = (trial >= {1'b0, den_i});
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = num_i;
      rem_d  = '0;
      cnt_d  = CW'(macd_pkg::NumW - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = qbit ? macd_pkg::PerW'(trial - {1'b0, den_i})
                    : trial[macd_pkg::PerW-1:0];
      work_d = {work_q[macd_pkg::NumW-2:0], qbit};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = work_q;

  // no restart while a division runs
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q) else $error("divider restarted while busy");

  // done follows the last step
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!run_q && $past(run_q))) else $error("stray divider done");

  // partial remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && $past(run_q)) |-> (rem_q < den_i)) else $error("remainder out of range");

endmodule

`default_nettype wire

// ----- rtl/macd_dp.sv -----
// ----------------------------------------------------------------------------
// macd_dp: MACD datapath
// Running state, seed sums, operand selection for the shared divider,
// saturating updates and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire macd_pkg::ctrl_cmd_t         cmd_i,
  input  wire logic [macd_pkg::PerW-1:0]   fast_reg_i,
  input  wire logic [macd_pkg::PerW-1:0]   slow_reg_i,
  input  wire logic [macd_pkg::PerW-1:0]   signal_reg_i,
  input  wire logic [macd_pkg::PriceW-1:0] close_price_i,
  input  wire logic                        series_start_i,
  output macd_pkg::dp_stat_t               stat_o,
  output logic [macd_pkg::ValW-1:0]        dif_value_o,
  output logic [macd_pkg::ValW-1:0]        dea_value_o,
  output logic [macd_pkg::ValW-1:0]        hist_value_o,
  output logic                             dif_valid_o,
  output logic                             dea_valid_o,
  output logic                             period_error_o
);

  localparam int VW = macd_pkg::ValW;
  localparam int WW = macd_pkg::WideW;

  logic [macd_pkg::PriceW-1:0]  price_q;
  logic [macd_pkg::CntW-1:0]    bar_count_q;
  logic [VW-1:0]                fast_avg_q, slow_avg_q, sig_avg_q, dif_q;
  logic [macd_pkg::SeedW-1:0]   fast_sum_q, slow_sum_q;
  logic [macd_pkg::SigSumW-1:0] sig_sum_q;
  logic                         neg_q;

  logic [VW-1:0] dif_out_q, dea_out_q, hist_out_q;
  logic          dif_ok_q, dea_ok_q, err_out_q;

  logic [macd_pkg::PerW-1:0] pf, ps, pg;
  logic [macd_pkg::CntW-1:0] n, n_next, seed_end;
  logic                      err, dif_ok, dea_ok;

  // effective periods and series position
  always_comb begin
    pf       = macd_pkg::eff_period(fast_reg_i);
    ps       = macd_pkg::eff_period(slow_reg_i);
    pg       = macd_pkg::eff_period(signal_reg_i);
    err      = (pf >= ps);
    n        = bar_count_q;
    n_next   = (bar_count_q == macd_pkg::CountMax) ? bar_count_q
                                                   : bar_count_q + macd_pkg::CntW'(1);
    seed_end = {1'b0, ps} + {1'b0, pg} - macd_pkg::CntW'(1);
    dif_ok   = (n >= {1'b0, ps});
    dea_ok   = dif_ok && (n >= seed_end);
  end

  // operand selection for the current phase
  logic                      cur_need, cur_seed;
  logic signed [WW-1:0]      cur_num, cur_avg, abs_num;
  logic [macd_pkg::PerW-1:0] cur_den;
  logic [macd_pkg::NumW-1:0] div_num;
  logic [macd_pkg::NumW-1:0] quot;
  logic                      div_done;
  logic signed [WW-1:0]      price_w, qs, upd;
  logic [VW-1:0]             upd_val;

  always_comb begin
    price_w  = {{(WW-macd_pkg::PriceW){1'b0}}, price_q};
    cur_need = 1'b0;
    cur_seed = 1'b0;
    cur_num  = '0;
    cur_avg  = '0;
    cur_den  = pf;
    case (cmd_i.phase)
      macd_pkg::PH_FAST: begin
        cur_need = (n >= {1'b0, pf});
        cur_seed = (n == {1'b0, pf});
        cur_avg  = {{(WW-VW){fast_avg_q[VW-1]}}, fast_avg_q};
        cur_den  = cur_seed ? pf : pf + macd_pkg::PerW'(1);
        cur_num  = cur_seed ? {{(WW-macd_pkg::SeedW){1'b0}}, fast_sum_q}
                            : (price_w - cur_avg) <<< 1;
      end
      macd_pkg::PH_SLOW: begin
        cur_need = (n >= {1'b0, ps});
        cur_seed = (n == {1'b0, ps});
        cur_avg  = {{(WW-VW){slow_avg_q[VW-1]}}, slow_avg_q};
        cur_den  = cur_seed ? ps : ps + macd_pkg::PerW'(1);
        cur_num  = cur_seed ? {{(WW-macd_pkg::SeedW){1'b0}}, slow_sum_q}
                            : (price_w - cur_avg) <<< 1;
      end
      macd_pkg::PH_SIG: begin
        cur_need = dea_ok;
        cur_seed = (n == seed_end);
        cur_avg  = {{(WW-VW){sig_avg_q[VW-1]}}, sig_avg_q};
        cur_den  = cur_seed ? pg : pg + macd_pkg::PerW'(1);
        cur_num  = cur_seed
                 ? {{(WW-macd_pkg::SigSumW){sig_sum_q[macd_pkg::SigSumW-1]}}, sig_sum_q}
                 : ({{(WW-VW){dif_q[VW-1]}}, dif_q} - cur_avg) <<< 1;
      end
      default: begin
        cur_need = 1'b0;
      end
    endcase
    // magnitude plus half the divisor gives round half away from zero
    abs_num = cur_num[WW-1] ? -cur_num : cur_num;
    div_num = abs_num[macd_pkg::NumW-1:0]
            + {{(macd_pkg::NumW-macd_pkg::PerW){1'b0}}, cur_den >> 1};
    // signed quotient, added to the old average unless seeding
    qs      = neg_q ? -{{(WW-macd_pkg::NumW){1'b0}}, quot}
                    :  {{(WW-macd_pkg::NumW){1'b0}}, quot};
    upd     = cur_seed ? qs : cur_avg + qs;
    upd_val = macd_pkg::sat_val(upd);
  end

  macd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (cur_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // difference, seed sums and result
  logic [macd_pkg::SeedW:0] fast_add, slow_add;
  logic signed [WW-1:0]     dif_w, sig_add, hist_w;
  logic [VW-1:0]            dif_new;

  always_comb begin
    fast_add = {1'b0, fast_sum_q} + {{(macd_pkg::SeedW+1-macd_pkg::PriceW){1'b0}}, price_q};
    slow_add = {1'b0, slow_sum_q} + {{(macd_pkg::SeedW+1-macd_pkg::PriceW){1'b0}}, price_q};
    dif_w    = {{(WW-VW){fast_avg_q[VW-1]}}, fast_avg_q}
             - {{(WW-VW){slow_avg_q[VW-1]}}, slow_avg_q};
    dif_new  = macd_pkg::sat_val(dif_w);
    sig_add  = {{(WW-macd_pkg::SigSumW){sig_sum_q[macd_pkg::SigSumW-1]}}, sig_sum_q}
             + {{(WW-VW){dif_new[VW-1]}}, dif_new};
    hist_w   = ({{(WW-VW){dif_q[VW-1]}}, dif_q}
             - {{(WW-VW){sig_avg_q[VW-1]}}, sig_avg_q}) <<< 1;
  end

  // running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_count_q <= '0;
      fast_avg_q  <= '0;
      slow_avg_q  <= '0;
      sig_avg_q   <= '0;
      fast_sum_q  <= '0;
      slow_sum_q  <= '0;
      sig_sum_q   <= '0;
    end else begin
      if (cmd_i.load && series_start_i) begin
        bar_count_q <= '0;
        fast_avg_q  <= '0;
        slow_avg_q  <= '0;
        sig_avg_q   <= '0;
        fast_sum_q  <= '0;
        slow_sum_q  <= '0;
        sig_sum_q   <= '0;
      end
      if (cmd_i.prep) begin
        bar_count_q <= n_next;
        if (n_next <= {1'b0, pf})
          fast_sum_q <= fast_add[macd_pkg::SeedW] ? '1 : fast_add[macd_pkg::SeedW-1:0];
        if (n_next <= {1'b0, ps})
          slow_sum_q <= slow_add[macd_pkg::SeedW] ? '1 : slow_add[macd_pkg::SeedW-1:0];
      end
      if (cmd_i.dif && dif_ok && (n <= seed_end))
        sig_sum_q <= macd_pkg::sat_sig(sig_add);
      if (cmd_i.div_write) begin
        case (cmd_i.phase)
          macd_pkg::PH_FAST: fast_avg_q <= upd_val;
          macd_pkg::PH_SLOW: slow_avg_q <= upd_val;
          macd_pkg::PH_SIG:  sig_avg_q  <= upd_val;
          default:           sig_avg_q  <= sig_avg_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load)      price_q <= close_price_i;
    if (cmd_i.div_start) neg_q   <= cur_num[WW-1];
    if (cmd_i.dif)       dif_q   <= dif_new;
    if (cmd_i.out_load) begin
      dif_ok_q   <= !err && dif_ok;
      dea_ok_q   <= !err && dea_ok;
      err_out_q  <= err;
      dif_out_q  <= (!err && dif_ok) ? dif_q : '0;
      dea_out_q  <= (!err && dea_ok) ? sig_avg_q : '0;
      hist_out_q <= (!err && dea_ok) ? macd_pkg::sat_val(hist_w) : '0;
    end
  end

  assign stat_o.err      = err;
  assign stat_o.need_div = cur_need;
  assign stat_o.div_done = div_done;

  assign dif_value_o    = dif_out_q;
  assign dea_value_o    = dea_out_q;
  assign hist_value_o   = hist_out_q;
  assign dif_valid_o    = dif_ok_q;
  assign dea_valid_o    = dea_ok_q;
  assign period_error_o = err_out_q;

  // averages only move through a divider write or a series restart
  a_avg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.div_write && !cmd_i.load) |=> $stable(fast_avg_q) && $stable(slow_avg_q))
    else $error("average changed without an update");

  // bar count moves only on prep or restart
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.prep && !cmd_i.load) |=> $stable(bar_count_q))
    else $error("bar count changed unexpectedly");

  // a written result never claims dea without dif
  a_valid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.out_load) |-> (!dea_ok_q || dif_ok_q))
    else $error("dea valid without dif valid");

endmodule

`default_nettype wire

// ----- rtl/macd_ctrl.sv -----
// ----------------------------------------------------------------------------
// macd_ctrl: MACD sequencer
// Steps one bar through prep, fast, slow, difference and signal phases and
// owns the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire macd_pkg::dp_stat_t stat_i,
  output macd_pkg::ctrl_cmd_t     cmd_o
);

  macd_pkg::ctrl_state_e state_q, state_d;
  macd_pkg::phase_e      phase_q, phase_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= macd_pkg::S_IDLE;
      phase_q     <= macd_pkg::PH_FAST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    in_ready_o  = 1'b0;
    case (state_q)
      macd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = macd_pkg::S_PREP;
        end
      end
      macd_pkg::S_PREP: begin
        if (stat_i.err) begin
          state_d = macd_pkg::S_RESULT;
        end else begin
          cmd_o.prep = 1'b1;
          phase_d    = macd_pkg::PH_FAST;
          state_d    = macd_pkg::S_DIV_START;
        end
      end
      macd_pkg::S_DIV_START, macd_pkg::S_DIV_WRITE: begin
        if (state_q == macd_pkg::S_DIV_START && stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = macd_pkg::S_DIV_RUN;
        end else begin
          cmd_o.div_write = (state_q == macd_pkg::S_DIV_WRITE);
          case (phase_q)
            macd_pkg::PH_FAST: begin
              phase_d = macd_pkg::PH_SLOW;
              state_d = macd_pkg::S_DIV_START;
            end
            macd_pkg::PH_SLOW: state_d = macd_pkg::S_DIF;
            default:           state_d = macd_pkg::S_RESULT;
          endcase
        end
      end
      macd_pkg::S_DIV_RUN: begin
        if (stat_i.div_done) state_d = macd_pkg::S_DIV_WRITE;
      end
      macd_pkg::S_DIF: begin
        cmd_o.dif = 1'b1;
        phase_d   = macd_pkg::PH_SIG;
        state_d   = macd_pkg::S_DIV_START;
      end
      macd_pkg::S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = macd_pkg::S_IDLE;
        end
      end
      default: state_d = macd_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // result register only reloads once the old beat has gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  // divider starts only when an operation needs it
  a_start_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> (stat_i.need_div && state_q == macd_pkg::S_DIV_START))
    else $error("needless divider start");

  // waiting divider holds the sequencer
  a_run_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == macd_pkg::S_DIV_RUN && !stat_i.div_done) |=> state_q == macd_pkg::S_DIV_RUN)
    else $error("left divider wait early");

endmodule

`default_nettype wire
